FILE: sv/csc_pkg.sv
// Color space converter package: beat payload types and the codes and
// weights shared by the converter. No dependencies.
package csc_pkg;

    // Color space codes, used for both the source space and the target
    typedef enum logic [1:0] {
        SPACE_GRAY = 2'd0,
        SPACE_RGB  = 2'd1,
        SPACE_CMYK = 2'd2,
        SPACE_RSVD = 2'd3
    } t_space;

    // Luma weights over 256 and the rounding offset
    localparam logic [7:0]  LUMA_WR    = 8'd77;
    localparam logic [7:0]  LUMA_WG    = 8'd150;
    localparam logic [7:0]  LUMA_WB    = 8'd29;
    localparam logic [15:0] LUMA_ROUND = 16'd128;

    // Full scale of one component
    localparam logic [7:0] FULL = 8'd255;

    // Input beat
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] source_space;
        logic [7:0] in_c0;
        logic [7:0] in_c1;
        logic [7:0] in_c2;
        logic [7:0] in_c3;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [1:0] out_space;
        logic [7:0] out_c0;
        logic [7:0] out_c1;
        logic [7:0] out_c2;
        logic [7:0] out_c3;
    } t_out;

endpackage

FILE: sv/color_space_converter_unit.sv
// Color space converter top level: gray / RGB / CMYK conversion in a
// nine-stage pipeline with a restoring divider for RGB to CMYK.
// Depends on csc_pkg.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+----------------------
//   input   | i_valid | o_stall | i_data (csc_pkg::t_in)
//   output  | o_valid | i_stall | o_data (csc_pkg::t_out)
//
// One beat enters per cycle while o_stall is low; a beat passes through every
// stage register in order before it leaves on o_data. The depth
// is set by the radix-4 divider (four stages, two quotient bits each) behind
// the product, scale, luma/max and setup stages, plus the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under stall and o_stall rises only when all nine are full.
// Reset (synchronous, active low) clears only the stage valid bits.
module color_space_converter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  csc_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output csc_pkg::t_out  o_data
);
    import csc_pkg::*;

    localparam int NUM_ST  = 9;   // total register stages
    localparam int DIV_ST  = 4;   // divider stages after setup
    localparam int SETUP   = 3;   // stage index of divider setup

    // Result with all but the quotients settled, plus a divide flag
    typedef struct packed {
        t_out res;
        logic use_div;
    } t_side;

    // Stage valids and advance enables
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] w_en;

    // Stage 1: products
    logic [1:0]  r1_kind, r1_src;
    logic [7:0]  r1_c [4];
    logic [15:0] r1_p [3];
    logic [15:0] n1_p [3];

    // Stage 2: RGB
    logic [1:0]  r2_kind, r2_src;
    logic [7:0]  r2_c [4];
    logic [7:0]  r2_rgb [3];
    logic [7:0]  n2_rgb [3];

    // Stage 3: luma and max
    logic [1:0]  r3_kind, r3_src;
    logic [7:0]  r3_c [4];
    logic [7:0]  r3_rgb [3];
    logic [7:0]  r3_gray, r3_mx;
    logic [15:0] n3_luma;
    logic [7:0]  n3_mx;

    // Divider: index 0 is setup, 1..DIV_ST the iterations
    logic [16:0] r_dv_rem  [DIV_ST+1][3];
    logic [7:0]  r_dv_q    [DIV_ST+1][3];
    logic [8:0]  r_dv_den  [DIV_ST+1];
    t_side       r_dv_side [DIV_ST+1];
    logic [16:0] n_dv_rem  [DIV_ST+1][3];
    logic [7:0]  n_dv_q    [DIV_ST+1][3];
    t_side       n_side;

    // Output register
    t_out r_out;
    t_out n_out;

    // Advance chain from the output back to the input
    always_comb begin
        w_en[NUM_ST-1] = !r_vld[NUM_ST-1] || !i_stall;
        for (int s = NUM_ST - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NUM_ST-1];
    assign o_data  = r_out;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NUM_ST; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage 1: (255-c)*(255-k) for the three chroma lanes
    always_comb begin
        logic [7:0] v_ink [3];
        logic [7:0] v_kinv;
        v_ink[0] = FULL - i_data.in_c0;
        v_ink[1] = FULL - i_data.in_c1;
        v_ink[2] = FULL - i_data.in_c2;
        v_kinv   = FULL - i_data.in_c3;
        for (int l = 0; l < 3; l++) begin
            n1_p[l] = 16'(v_ink[l]) * 16'(v_kinv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_kind <= i_data.kind;
            r1_src  <= i_data.source_space;
            r1_c[0] <= i_data.in_c0;
            r1_c[1] <= i_data.in_c1;
            r1_c[2] <= i_data.in_c2;
            r1_c[3] <= i_data.in_c3;
            r1_p    <= n1_p;
        end
    end

    // Stage 2: rounded divide by 255, then pick RGB by source space
    always_comb begin
        logic [15:0] v_y;
        logic [23:0] v_scaled;
        logic [7:0]  v_qe;
        logic [16:0] v_rem;
        logic [7:0]  v_div [3];
        for (int l = 0; l < 3; l++) begin
            v_y      = r1_p[l] + 16'd127;
            v_scaled = 24'(v_y) + {v_y, 8'd0};
            v_qe     = v_scaled[23:16];
            v_rem    = 17'(v_y) + 17'(v_qe) - {1'b0, v_qe, 8'd0};
            v_div[l] = (v_rem >= 17'(FULL)) ? v_qe + 8'd1 : v_qe;
        end
        unique case (t_space'(r1_src))
            SPACE_GRAY: begin
                for (int l = 0; l < 3; l++) n2_rgb[l] = r1_c[0];
            end
            SPACE_RGB: begin
                for (int l = 0; l < 3; l++) n2_rgb[l] = r1_c[l];
            end
            SPACE_CMYK: begin
                n2_rgb = v_div;
            end
            default: begin
                for (int l = 0; l < 3; l++) n2_rgb[l] = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_kind <= r1_kind;
            r2_src  <= r1_src;
            r2_c    <= r1_c;
            r2_rgb  <= n2_rgb;
        end
    end

    // Stage 3: luma sum and max of the three components
    always_comb begin
        n3_luma = 16'(LUMA_WR) * 16'(r2_rgb[0]) + 16'(LUMA_WG) * 16'(r2_rgb[1])
                + 16'(LUMA_WB) * 16'(r2_rgb[2]) + LUMA_ROUND;
        n3_mx = (r2_rgb[1] > r2_rgb[0]) ? r2_rgb[1] : r2_rgb[0];
        if (r2_rgb[2] > n3_mx) begin
            n3_mx = r2_rgb[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_kind <= r2_kind;
            r3_src  <= r2_src;
            r3_c    <= r2_c;
            r3_rgb  <= r2_rgb;
            r3_gray <= n3_luma[15:8];
            r3_mx   <= n3_mx;
        end
    end

    // Stage 4: settle the result by target space
    always_comb begin
        n_side = '0;
        n_side.res.out_space = r3_kind;
        unique case (t_space'(r3_kind))
            SPACE_GRAY: begin
                n_side.res.out_c0 = r3_gray;
            end
            SPACE_RGB: begin
                n_side.res.out_c0 = r3_rgb[0];
                n_side.res.out_c1 = r3_rgb[1];
                n_side.res.out_c2 = r3_rgb[2];
            end
            SPACE_CMYK: begin
                if (t_space'(r3_src) == SPACE_CMYK) begin
                    n_side.res.out_c0 = r3_c[0];
                    n_side.res.out_c1 = r3_c[1];
                    n_side.res.out_c2 = r3_c[2];
                    n_side.res.out_c3 = r3_c[3];
                end else begin
                    // black source leaves c, m and y at zero
                    n_side.res.out_c3 = FULL - r3_mx;
                    n_side.use_div    = (r3_mx != 8'd0);
                end
            end
            default: ;
        endcase
    end

    // Divider setup and iterations: two restoring steps per stage, MSB first
    always_comb begin
        logic [7:0]  v_n;
        logic [16:0] v_rem, v_trial;
        logic [7:0]  v_q;
        logic [2:0]  v_b;
        // c = floor((510*(mx-r) + mx) / (2*mx)), the rounded (mx-r)*255/mx
        for (int l = 0; l < 3; l++) begin
            v_n = r3_mx - r3_rgb[l];
            n_dv_rem[0][l] = {v_n, 9'd0} - {8'd0, v_n, 1'b0} + 17'(r3_mx);
            n_dv_q[0][l]   = 8'd0;
        end
        for (int j = 1; j <= DIV_ST; j++) begin
            for (int l = 0; l < 3; l++) begin
                v_rem = r_dv_rem[j-1][l];
                v_q   = r_dv_q[j-1][l];
                for (int t = 0; t < 2; t++) begin
                    v_b     = 3'(9 - 2 * j - t);
                    v_trial = 17'(r_dv_den[j-1]) << v_b;
                    if (v_rem >= v_trial) begin
                        v_rem    = v_rem - v_trial;
                        v_q[v_b] = 1'b1;
                    end
                end
                n_dv_rem[j][l] = v_rem;
                n_dv_q[j][l]   = v_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[SETUP]) begin
            r_dv_side[0] <= n_side;
            r_dv_den[0]  <= {r3_mx, 1'b0};
            r_dv_rem[0]  <= n_dv_rem[0];
            r_dv_q[0]    <= n_dv_q[0];
        end
        for (int j = 1; j <= DIV_ST; j++) begin
            if (w_en[SETUP+j]) begin
                r_dv_side[j] <= r_dv_side[j-1];
                r_dv_den[j]  <= r_dv_den[j-1];
                r_dv_rem[j]  <= n_dv_rem[j];
                r_dv_q[j]    <= n_dv_q[j];
            end
        end
    end

    // Output stage: drop the quotients into c, m and y where needed
    always_comb begin
        n_out = r_dv_side[DIV_ST].res;
        if (r_dv_side[DIV_ST].use_div) begin
            n_out.out_c0 = r_dv_q[DIV_ST][0];
            n_out.out_c1 = r_dv_q[DIV_ST][1];
            n_out.out_c2 = r_dv_q[DIV_ST][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NUM_ST-1]) begin
            r_out <= n_out;
        end
    end

    // A stall toward the source means every stage holds a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat not captured");

    // Divider finishes with a remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SETUP+DIV_ST] && r_dv_side[DIV_ST].use_div) |->
        ((r_dv_rem[DIV_ST][0] < 17'(r_dv_den[DIV_ST])) &&
         (r_dv_rem[DIV_ST][1] < 17'(r_dv_den[DIV_ST])) &&
         (r_dv_rem[DIV_ST][2] < 17'(r_dv_den[DIV_ST]))))
        else $error("divider remainder out of range");

    // Reserved target space gives all components zero
    a_rsvd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.out_space == SPACE_RSVD)) |->
        ((o_data.out_c0 == 8'd0) && (o_data.out_c1 == 8'd0) &&
         (o_data.out_c2 == 8'd0) && (o_data.out_c3 == 8'd0)))
        else $error("reserved target space with nonzero components");

endmodule

FILE: test/csc_conversion_checker.sv
// Conversion checker for the color space converter: watches both channels,
// predicts each converted color and compares it with the output beat.
// Depends on csc_pkg.
module csc_conversion_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_in_stall,
    input  csc_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_stall,
    input  csc_pkg::t_out  i_out_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import csc_pkg::*;

    // Luma weights over 256, kept separate from the design's copy
    localparam int unsigned WEIGHT_R   = 77;
    localparam int unsigned WEIGHT_G   = 150;
    localparam int unsigned WEIGHT_B   = 29;
    localparam int unsigned COMP_MAX   = 255;

    t_out expected_colors[$];
    int   error_cnt = 0;
    int   checked_cnt = 0;

    assign o_errors  = error_cnt;
    assign o_checked = checked_cnt;

    // num/den rounded half up
    function automatic logic [7:0] div_round(input int unsigned num, input int unsigned den);
        return 8'((2 * num + den) / (2 * den));
    endfunction

    // Bring the source color into RGB; index 0 is red
    function automatic logic [2:0][7:0] source_to_rgb(input t_in px);
        logic [2:0][7:0] rgb;
        logic [3:0][7:0] comp;
        int unsigned     ink;
        int unsigned     black;
        comp = {px.in_c3, px.in_c2, px.in_c1, px.in_c0};
        rgb  = '0;
        case (t_space'(px.source_space))
            SPACE_GRAY: begin
                rgb = {3{px.in_c0}};
            end
            SPACE_RGB: begin
                rgb = {px.in_c2, px.in_c1, px.in_c0};
            end
            SPACE_CMYK: begin
                black = COMP_MAX - int'(comp[3]);
                for (int i = 0; i < 3; i++) begin
                    ink    = COMP_MAX - int'(comp[i]);
                    rgb[i] = div_round(ink * black, COMP_MAX);
                end
            end
            default: begin
                // reserved source reads as RGB black
                rgb = '0;
            end
        endcase
        return rgb;
    endfunction

    // Expected output beat for one input beat
    function automatic t_out convert_color(input t_in px);
        t_out            res;
        logic [2:0][7:0] rgb;
        int unsigned     peak;
        int unsigned     luma;
        res           = '0;
        res.out_space = px.kind;
        rgb           = source_to_rgb(px);
        case (t_space'(px.kind))
            SPACE_GRAY: begin
                if (t_space'(px.source_space) == SPACE_GRAY) begin
                    res.out_c0 = px.in_c0;
                end else begin
                    luma = WEIGHT_R * rgb[0] + WEIGHT_G * rgb[1] + WEIGHT_B * rgb[2] + 128;
                    res.out_c0 = 8'(luma >> 8);
                end
            end
            SPACE_RGB: begin
                res.out_c0 = rgb[0];
                res.out_c1 = rgb[1];
                res.out_c2 = rgb[2];
            end
            SPACE_CMYK: begin
                if (t_space'(px.source_space) == SPACE_CMYK) begin
                    res.out_c0 = px.in_c0;
                    res.out_c1 = px.in_c1;
                    res.out_c2 = px.in_c2;
                    res.out_c3 = px.in_c3;
                end else begin
                    peak = 32'(rgb[0]);
                    if (rgb[1] > peak) peak = 32'(rgb[1]);
                    if (rgb[2] > peak) peak = 32'(rgb[2]);
                    res.out_c3 = 8'(COMP_MAX - peak);
                    // black leaves c, m and y at zero
                    if (peak != 0) begin
                        res.out_c0 = div_round((peak - rgb[0]) * COMP_MAX, peak);
                        res.out_c1 = div_round((peak - rgb[1]) * COMP_MAX, peak);
                        res.out_c2 = div_round((peak - rgb[2]) * COMP_MAX, peak);
                    end
                end
            end
            default: begin
                // reserved target: all components zero
            end
        endcase
        return res;
    endfunction

    // Report one field; returns 1 on a mismatch
    function automatic int field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_out want;
        int   bad;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall) begin
                expected_colors.push_back(convert_color(i_in_data));
            end
            if (i_out_valid && !i_stall) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: output beat with nothing expected, actual %h",
                             $time, i_out_data);
                    error_cnt++;
                end else begin
                    want = expected_colors.pop_front();
                    bad  = field_differs("out_space", {6'd0, want.out_space},
                                         {6'd0, i_out_data.out_space})
                         + field_differs("out_c0", want.out_c0, i_out_data.out_c0)
                         + field_differs("out_c1", want.out_c1, i_out_data.out_c1)
                         + field_differs("out_c2", want.out_c2, i_out_data.out_c2)
                         + field_differs("out_c3", want.out_c3, i_out_data.out_c3);
                    if (bad != 0) error_cnt++;
                    checked_cnt++;
                end
            end
        end
        o_pending <= expected_colors.size();
    end

endmodule

FILE: test/tb.sv
// Testbench top for color_space_converter_unit: drives directed and random
// colors with bursty input and patterned output stalls, gives the verdict.
// Depends on csc_pkg and csc_conversion_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csc_pkg::*;

    localparam int RANDOM_BEATS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 30;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    int errors;
    int pending;
    int checked;
    int burst_left;
    int stall_left;
    int stall_mode;

    color_space_converter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    csc_conversion_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_stall     (i_stall),
        .i_out_data  (o_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Output stall pattern: stretches of free flow, light, heavy and solid stall
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(4, 30) : $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= 1'b1;
        endcase
    end

    function automatic t_in make_color(input t_space target, input t_space src,
                                       input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3);
        t_in px;
        px.kind         = target;
        px.source_space = src;
        px.in_c0        = c0;
        px.in_c1        = c1;
        px.in_c2        = c2;
        px.in_c3        = c3;
        return px;
    endfunction

    // Component biased toward the extremes
    function automatic logic [7:0] random_component();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Space code, reserved code now and then
    function automatic t_space random_space();
        if ($urandom_range(0, 15) == 0) return SPACE_RSVD;
        return t_space'($urandom_range(0, 2));
    endfunction

    function automatic t_in random_color();
        return make_color(random_space(), random_space(), random_component(),
                          random_component(), random_component(), random_component());
    endfunction

    // Present one beat and hold it until accepted
    task automatic send_beat(input t_in px);
        i_data  <= px;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every predicted color has come out
    task automatic drain_outputs();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        t_in directed[$];
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every target/source pair, reserved codes included
        for (int t = 0; t < 4; t++) begin
            for (int s = 0; s < 4; s++) begin
                directed.push_back(make_color(t_space'(t), t_space'(s),
                                              8'd200, 8'd100, 8'd50, 8'd30));
            end
        end
        // Black into CMYK, from RGB and from gray
        directed.push_back(make_color(SPACE_CMYK, SPACE_RGB, 8'd0, 8'd0, 8'd0, 8'd255));
        directed.push_back(make_color(SPACE_CMYK, SPACE_GRAY, 8'd0, 8'd255, 8'd255, 8'd255));
        // Full black ink
        directed.push_back(make_color(SPACE_RGB, SPACE_CMYK, 8'd10, 8'd20, 8'd30, 8'd255));
        directed.push_back(make_color(SPACE_CMYK, SPACE_CMYK, 8'd255, 8'd255, 8'd255, 8'd255));
        // White and extremes
        directed.push_back(make_color(SPACE_GRAY, SPACE_RGB, 8'd255, 8'd255, 8'd255, 8'd0));
        directed.push_back(make_color(SPACE_GRAY, SPACE_CMYK, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_color(SPACE_CMYK, SPACE_RGB, 8'd255, 8'd255, 8'd255, 8'd255));
        // Unused components carry junk
        directed.push_back(make_color(SPACE_RGB, SPACE_GRAY, 8'd128, 8'd255, 8'd255, 8'd255));
        directed.push_back(make_color(SPACE_CMYK, SPACE_RSVD, 8'd255, 8'd255, 8'd255, 8'd255));

        foreach (directed[i]) send_beat(directed[i]);
        drain_outputs();

        // Random colors in bursts of random length
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 2) drain_outputs();
            send_beat(random_color());
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
            end else begin
                burst_left--;
            end
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d converted colors over all target/source pairs, reserved codes",
                 checked);
        $display("included, with bursty input, patterned output stalls and full drains.");
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/csc_pkg.sv
sv/color_space_converter_unit.sv
test/csc_conversion_checker.sv
test/tb.sv
